/* src/bffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int MAP_BITS     = 8192;
  localparam int WORD_BITS    = 32;
  localparam int MAP_WORDS    = MAP_BITS / WORD_BITS;
  localparam int ADDR_W       = $clog2(MAP_WORDS);
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int IDX_W        = ADDR_W + BIT_W;
  localparam int NUM_W        = 14;
  localparam int CMP_W        = 32;
  localparam int MAP_SIZE_RST = 8192;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_FULL         = 2'd1,
    STS_RANGE        = 2'd2,
    STS_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    req_e             req_type;
    logic [NUM_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0] granted_number;
    status_e          status;
    logic [NUM_W-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

/* src/bitmap_first_fit_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// First-fit allocator over a bitmap memory with a used-entry count.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       in         in_valid_i / in_stall_o   req_t  (req_type, entry_number)
//  out      out        out_valid_o / out_stall_i rsp_t  (granted, status, free_count)
//  cfg      in         cfg_we_i                  cfg_data_i (map_size)
//
//  Allocate scans the bitmap words in order (1 to MAP_BITS/32 of them),
//  one word per cycle through the single read port of the bitmap memory.
//  Free steps through read, modify-write, result. A rejected request goes straight to the result.
//  Reset clears the count and the per-row valid bits at once; no clearing pass.
//  A stalled result waits in the output register; the next item is taken
//  meanwhile, and its result holds until that register frees up.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bffa_pkg::req_t             in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bffa_pkg::rsp_t             out_item_o,
  input  logic                       cfg_we_i,
  input  logic [bffa_pkg::NUM_W-1:0] cfg_data_i
);
  import bffa_pkg::*;

  logic [NUM_W-1:0]     map_size_q;
  mem_req_t             mreq;
  logic [WORD_BITS-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= NUM_W'(MAP_SIZE_RST);
    end else if (cfg_we_i) begin
      map_size_q <= cfg_data_i;
    end
  end

  bffa_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mreq_i    (mreq),
    .rd_data_o (rd_data)
  );

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_size_i  (map_size_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .mreq_o      (mreq),
    .rd_data_i   (rd_data)
  );

endmodule

/* src/bffa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ram
// Bitmap word memory, one read and one write port, registered read data.
// Per-row valid bits make unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module bffa_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bffa_pkg::mem_req_t            mreq_i,
  output logic [bffa_pkg::WORD_BITS-1:0] rd_data_o
);
  import bffa_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_vld_q;
  logic [WORD_BITS-1:0] rd_word_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (mreq_i.wr_en) begin
      mem[mreq_i.wr_addr] <= mreq_i.wr_data;
    end
    if (mreq_i.rd_en) begin
      rd_word_q <= mem[mreq_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mreq_i.wr_en) begin
        row_vld_q[mreq_i.wr_addr] <= 1'b1;
      end
      if (mreq_i.rd_en) begin
        rd_vld_q <= row_vld_q[mreq_i.rd_addr];
      end
    end
  end

  // a row never written holds the reset value
  assign rd_data_o = rd_vld_q ? rd_word_q : '0;

endmodule

/* src/bffa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl
// Request sequencer: word scan for allocate, read-modify-write for free,
// used-entry count and the result register.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bffa_pkg::NUM_W-1:0]     map_size_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bffa_pkg::req_t                 in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bffa_pkg::rsp_t                 out_item_o,
  output bffa_pkg::mem_req_t             mreq_o,
  input  logic [bffa_pkg::WORD_BITS-1:0] rd_data_i
);
  import bffa_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] word_q, word_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [NUM_W-1:0]  used_q, used_d;
  logic [NUM_W-1:0]  grant_q, grant_d;
  status_e           sts_q, sts_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_item_q, out_item_d;

  logic [NUM_W-1:0]     size;
  logic [NUM_W-1:0]     idx;
  logic                 accept;
  logic                 slot_free;
  logic [WORD_BITS-1:0] zeros;
  logic                 any_zero;
  logic [BIT_W-1:0]     first_zero;
  logic [IDX_W-1:0]     hit_idx;
  logic [ADDR_W:0]      nxt_word;
  logic [IDX_W:0]       nxt_base;
  logic [WORD_BITS-1:0] bit_mask;

  assign size = (CMP_W'(map_size_i) > CMP_W'(MAP_BITS)) ? NUM_W'(MAP_BITS) : map_size_i;
  assign idx  = in_item_i.entry_number - NUM_W'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // lowest clear bit of the word just read
  assign zeros = ~rd_data_i;
  always_comb begin
    first_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (zeros[i]) begin
        first_zero = BIT_W'(i);
      end
    end
  end
  assign any_zero = |zeros;
  assign hit_idx  = {word_q, first_zero};
  assign nxt_word = {1'b0, word_q} + (ADDR_W+1)'(1);
  assign nxt_base = {nxt_word, BIT_W'(0)};
  assign bit_mask = WORD_BITS'(1) << bit_q;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    bit_d       = bit_q;
    used_d      = used_q;
    grant_d     = grant_q;
    sts_d       = sts_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    mreq_o      = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          grant_d = '0;
          if (in_item_i.req_type == REQ_ALLOC) begin
            if (size == '0) begin
              sts_d   = STS_FULL;
              state_d = S_DONE;
            end else begin
              mreq_o.rd_en   = 1'b1;
              mreq_o.rd_addr = '0;
              word_d         = '0;
              state_d        = S_SCAN;
            end
          end else begin
            if (in_item_i.entry_number == '0 || in_item_i.entry_number > size) begin
              sts_d   = STS_RANGE;
              state_d = S_DONE;
            end else begin
              mreq_o.rd_en   = 1'b1;
              mreq_o.rd_addr = idx[IDX_W-1:BIT_W];
              word_d         = idx[IDX_W-1:BIT_W];
              bit_d          = idx[BIT_W-1:0];
              state_d        = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        priority if (any_zero && (CMP_W'(hit_idx) < CMP_W'(size))) begin
          mreq_o.wr_en   = 1'b1;
          mreq_o.wr_addr = word_q;
          mreq_o.wr_data = rd_data_i | (WORD_BITS'(1) << first_zero);
          used_d         = used_q + NUM_W'(1);
          grant_d        = NUM_W'(hit_idx) + NUM_W'(1);
          sts_d          = STS_OK;
          state_d        = S_DONE;
        end else if (any_zero || (CMP_W'(nxt_base) >= CMP_W'(size))) begin
          sts_d   = STS_FULL;
          state_d = S_DONE;
        end else begin
          // advance to the next word, one read per cycle
          mreq_o.rd_en   = 1'b1;
          mreq_o.rd_addr = nxt_word[ADDR_W-1:0];
          word_d         = nxt_word[ADDR_W-1:0];
        end
      end
      S_FREE: begin
        if ((rd_data_i & bit_mask) == '0) begin
          sts_d = STS_ALREADY_FREE;
        end else begin
          mreq_o.wr_en   = 1'b1;
          mreq_o.wr_addr = word_q;
          mreq_o.wr_data = rd_data_i & ~bit_mask;
          if (used_q != '0) begin
            used_d = used_q - NUM_W'(1);
          end
          sts_d = STS_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (slot_free) begin
          out_valid_d               = 1'b1;
          out_item_d.granted_number = grant_q;
          out_item_d.status         = sts_q;
          out_item_d.free_count     = (size > used_q) ? (size - used_q) : '0;
          state_d                   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    bit_q      <= bit_d;
    grant_q    <= grant_d;
    sts_q      <= sts_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_write_in_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq_o.wr_en |-> (state_q == S_SCAN || state_q == S_FREE))
    else $error("bitmap write outside a read-modify-write step");

  a_write_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq_o.wr_en |-> ($countones(mreq_o.wr_data ^ rd_data_i) == 1))
    else $error("bitmap write changes other than one bit");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(used_q) <= CMP_W'(MAP_BITS))
    else $error("used count above map size");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result issued outside the done state");

  a_no_read_while_idle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mreq_o.rd_en && state_q == S_IDLE) |-> accept)
    else $error("bitmap read without an accepted item");

endmodule

/* dv/tb_bitmap_first_fit_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_fit_allocator
// Drives allocate and free requests into the first-fit bitmap allocator with
// random gaps and result stalls. Checks every result against a behavioral
// bitmap that is kept in step with each accepted request. Covers map-size
// changes, including zero, saturation above the map and shrinking under
// set entries.
// ----------------------------------------------------------------------------
module tb_bitmap_first_fit_allocator;
  import bffa_pkg::*;

  // Behavioral copy of the allocator. Each accepted request queues its result.
  class alloc_scoreboard;
    bit [MAP_BITS-1:0] taken;
    logic [NUM_W-1:0]  used_cnt;
    logic [NUM_W-1:0]  size_reg;
    rsp_t              owed_rsp[$];
    int                errors;

    function new();
      taken    = '0;
      used_cnt = '0;
      size_reg = NUM_W'(MAP_SIZE_RST);
      errors   = 0;
    endfunction

    function void set_size(logic [NUM_W-1:0] v);
      size_reg = v;
    endfunction

    function int eff_size();
      return (int'(size_reg) > MAP_BITS) ? MAP_BITS : int'(size_reg);
    endfunction

    function void note_request(req_t r);
      int   lim;
      int   ucnt;
      int   i;
      int   num;
      rsp_t e;
      lim              = eff_size();
      num              = int'(r.entry_number);
      e.granted_number = '0;
      e.status         = STS_OK;
      if (r.req_type == REQ_ALLOC) begin
        e.status = STS_FULL;
        for (i = 0; i < lim; i++) begin
          if (!taken[i]) begin
            taken[i]         = 1'b1;
            used_cnt         = used_cnt + 1'b1;
            e.granted_number = NUM_W'(i + 1);
            e.status         = STS_OK;
            break;
          end
        end
      end else if (num == 0 || num > lim) begin
        e.status = STS_RANGE;
      end else if (!taken[num-1]) begin
        e.status = STS_ALREADY_FREE;
      end else begin
        taken[num-1] = 1'b0;
        if (used_cnt != 0) used_cnt = used_cnt - 1'b1;
      end
      ucnt         = int'(used_cnt);
      // Entries left set above a shrunk size can push the count past the size.
      e.free_count = (lim > ucnt) ? NUM_W'(lim - ucnt) : '0;
      owed_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (owed_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: granted %0d status %0d free %0d",
                   got.granted_number, got.status, got.free_count);
        return;
      end
      e = owed_rsp.pop_front();
      if (got.granted_number !== e.granted_number || got.status !== e.status ||
          got.free_count !== e.free_count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: got granted %0d status %0d free %0d, expected granted %0d status %0d free %0d",
                   got.granted_number, got.status, got.free_count,
                   e.granted_number, e.status, e.free_count);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  req_t             in_item;
  logic             out_valid;
  logic             out_stall;
  rsp_t             out_item;
  logic             cfg_we;
  logic [NUM_W-1:0] cfg_data;
  bit               calm;

  alloc_scoreboard sb = new();

  bitmap_first_fit_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("tb_bitmap_first_fit_allocator: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_item);
      if (out_valid && !out_stall) sb.check_response(out_item);
    end
  end

  // Result-side stalls in random bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one item and hold it until taken; returns on a falling edge.
  task automatic send_req(input req_e kind, input logic [NUM_W-1:0] num);
    req_t r;
    r.req_type     = kind;
    r.entry_number = num;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.owed_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_map_size(input logic [NUM_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_size(v);
  endtask

  task automatic run_phase(input int n_items, input int alloc_pct);
    int lim;
    int roll;
    int start;
    int pick;
    int idx;
    int k;
    for (int n = 0; n < n_items; n++) begin
      lim  = sb.eff_size();
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        // entry number is don't-care on allocate: fill it with noise
        send_req(REQ_ALLOC, NUM_W'($urandom));
      end else if (roll < 90 && lim > 0) begin
        // free an entry that is set, if any is within the size
        start = $urandom_range(0, lim - 1);
        pick  = start;
        for (k = 0; k < lim; k++) begin
          idx = (start + k) % lim;
          if (sb.taken[idx]) begin
            pick = idx;
            break;
          end
        end
        send_req(REQ_FREE, NUM_W'(pick + 1));
      end else begin
        case ($urandom_range(0, 3))
          0: send_req(REQ_FREE, '0);
          1: send_req(REQ_FREE, NUM_W'(lim + $urandom_range(1, 10)));
          2: send_req(REQ_FREE, NUM_W'($urandom));
          default: send_req(REQ_FREE, NUM_W'($urandom_range(1, (lim > 0) ? lim : 1)));
        endcase
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: range edges, double free, reuse of the lowest hole.
    send_req(REQ_FREE, '0);
    send_req(REQ_FREE, NUM_W'(8192));
    send_req(REQ_FREE, NUM_W'(8193));
    send_req(REQ_FREE, '1);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '1);
    send_req(REQ_FREE, NUM_W'(2));
    send_req(REQ_FREE, NUM_W'(2));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '1);
    send_req(REQ_FREE, NUM_W'(1));
    in_valid <= 1'b0;

    // Size zero: everything is full or out of range.
    write_map_size('0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, NUM_W'(1));
    in_valid <= 1'b0;

    // Shrink under set entries: free count saturates, upper entries locked.
    write_map_size(NUM_W'(3));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, NUM_W'(4));
    send_req(REQ_FREE, NUM_W'(3));
    in_valid <= 1'b0;

    // Size above the map saturates.
    write_map_size('1);
    send_req(REQ_FREE, NUM_W'(8192));
    send_req(REQ_FREE, NUM_W'(4));
    send_req(REQ_ALLOC, '0);
    in_valid <= 1'b0;

    write_map_size(NUM_W'(40));
    run_phase(150, 60);
    write_map_size(NUM_W'(1));
    run_phase(40, 50);
    write_map_size(NUM_W'(64));
    run_phase(160, 65);
    write_map_size(NUM_W'(16));
    run_phase(100, 45);
    write_map_size('1);
    run_phase(120, 55);
    write_map_size(NUM_W'(33));
    run_phase(120, 50);
    write_map_size(NUM_W'(100));
    run_phase(150, 60);
    write_map_size('0);
    run_phase(20, 50);
    write_map_size(NUM_W'(8192));
    run_phase(150, 70);
    write_map_size(NUM_W'(32));
    run_phase(100, 50);
    write_map_size(NUM_W'(200));
    calm = 1'b1;
    run_phase(140, 55);

    wait_drained();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.owed_rsp.size() == 0) begin
      $display("tb_bitmap_first_fit_allocator: clean");
    end else begin
      $display("tb_bitmap_first_fit_allocator: errors");
    end
    $finish;
  end

endmodule
